// ----- src/bba_pkg.sv -----
// Package for the block bitmap allocator: operation codes, status codes,
// configuration register indexes and field widths. No dependencies.
`default_nettype none

package bba_pkg;

  localparam int OP_W     = 3;
  localparam int IDX_W    = 12;
  localparam int CNT_W    = 13;
  localparam int STAT_W   = 2;
  localparam int CFG_A_W  = 1;
  localparam int CFG_D_W  = 13;

  localparam logic [OP_W-1:0] OP_FORMAT = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd2;
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_ALREADY = 2'd3;

  localparam logic [CFG_A_W-1:0] REG_TOTAL    = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_RESERVED = 1'd1;

  localparam logic [CNT_W-1:0] COUNT_MAX     = 13'h1fff;
  localparam logic [CNT_W-1:0] TOTAL_RESET   = 13'd4096;
  localparam logic [IDX_W-1:0] RESERVE_RESET = 12'd1;

endpackage

`default_nettype wire

// ----- src/bba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the occupancy map; no dependencies.
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/block_bitmap_allocator.sv -----
// An in-range read, write or free passes through S_DIV, S_RA, S_EV and S_PUT; an
// out-of-range one, other ops and an allocate with no free block go straight to S_PUT.
// One request at a time: the next input is taken once the result is registered in S_PUT,
// which waits while the output is stalled. Allocate and format take one map word a cycle.
// Reset is synchronous and active high; afterwards a clearing pass over all map words
// (128 by default) zeroes the map before the first input is taken. Needs bba_pkg, bba_ram.
`default_nettype none

module block_bitmap_allocator #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [bba_pkg::CFG_A_W-1:0] cfg_addr,
  input  wire logic [bba_pkg::CFG_D_W-1:0] cfg_wdata,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // s_tdata, lowest bit up: op[2:0], block_index[14:3], bit_value[15]
  input  wire logic [15:0]                 s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // m_tdata, lowest bit up: result_block[11:0], bit_read[12], free_count[25:13],
  // status[27:26], zero fill[31:28]
  output logic [31:0]                      m_tdata
);

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int BSPAN     = $clog2(MAP_WORDS * WORD_BITS + 1);
  localparam int BASE_W    = (BSPAN > bba_pkg::CNT_W) ? BSPAN : bba_pkg::CNT_W;
  localparam int DW0       = BIT_W + WA_W + 1;
  localparam int DW        = (DW0 > bba_pkg::CNT_W) ? DW0 : bba_pkg::CNT_W;
  localparam int DIV_SH    = bba_pkg::IDX_W + BIT_W;
  localparam int MW        = bba_pkg::IDX_W + 2;
  localparam int PW        = bba_pkg::IDX_W + MW;
  localparam logic [MW-1:0] DIV_M = MW'(((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS);
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(MAP_WORDS - 1);
  localparam logic [bba_pkg::CNT_W-1:0] MAX_CLAMP =
    (MAX_BLOCKS > 8191) ? bba_pkg::COUNT_MAX : bba_pkg::CNT_W'(MAX_BLOCKS);
  localparam logic [BASE_W-1:0] WB_BASE = BASE_W'(WORD_BITS);

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_FMT  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_RA   = 8'b0001_0000,
    S_EV   = 8'b0010_0000,
    S_SCAN = 8'b0100_0000,
    S_PUT  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [bba_pkg::CNT_W-1:0]  total_blocks;
  logic [bba_pkg::IDX_W-1:0]  reserved_blocks;
  logic [bba_pkg::CNT_W-1:0]  free_blocks;

  logic [bba_pkg::OP_W-1:0]   req_op;
  logic [bba_pkg::IDX_W-1:0]  req_idx;
  logic                       req_val;

  logic [WA_W-1:0]            sw_addr;
  logic [BASE_W-1:0]          sw_base;
  logic [bba_pkg::CNT_W-1:0]  fmt_rsv;

  logic [WA_W-1:0]            iss_addr;
  logic [BASE_W-1:0]          iss_base;
  logic                       iss_done;
  logic                       chk_valid;
  logic [WA_W-1:0]            chk_addr;
  logic [BASE_W-1:0]          chk_base;

  logic [DW-1:0]              div_rem;
  logic [WA_W-1:0]            div_q;
  logic [PW-1:0]              div_prod;
  logic [WA_W-1:0]            div_quo;
  logic [DW-1:0]              div_back;

  logic [bba_pkg::IDX_W-1:0]  res_block;
  logic                       res_bit;
  logic [bba_pkg::STAT_W-1:0] res_status;

  logic [bba_pkg::IDX_W-1:0]  out_block;
  logic                       out_bit;
  logic [bba_pkg::CNT_W-1:0]  out_count;
  logic [bba_pkg::STAT_W-1:0] out_status;

  logic [bba_pkg::OP_W-1:0]   in_op;
  logic [bba_pkg::IDX_W-1:0]  in_idx;
  logic                       in_val;

  logic [bba_pkg::CNT_W-1:0]  eff_total;
  logic [bba_pkg::CNT_W-1:0]  eff_rsv;
  logic                       in_range;
  logic                       sweep;

  logic [bba_pkg::CNT_W-1:0]  lim_op;
  logic [BASE_W-1:0]          base_op;
  logic [BASE_W:0]            lim_diff;
  logic                       lim_neg;
  logic [WORD_BITS-1:0]       lim_mask;
  logic                       lim_end;

  logic [WORD_BITS-1:0]       free_mask;
  logic                       free_any;
  logic [BIT_W-1:0]           free_pos;
  logic [BIT_W-1:0]           bit_pos;
  logic [WORD_BITS-1:0]       bit_one;

  logic                       ram_we;
  logic [WA_W-1:0]            ram_waddr;
  logic [WORD_BITS-1:0]       ram_wdata;
  logic [WA_W-1:0]            ram_raddr;
  logic [WORD_BITS-1:0]       ram_rdata;

  assign in_op  = s_tdata[2:0];
  assign in_idx = s_tdata[14:3];
  assign in_val = s_tdata[15];

  assign eff_total = (total_blocks > MAX_CLAMP) ? MAX_CLAMP : total_blocks;
  assign eff_rsv   = (bba_pkg::CNT_W'(reserved_blocks) > eff_total) ?
                     eff_total : bba_pkg::CNT_W'(reserved_blocks);
  assign in_range  = bba_pkg::CNT_W'(in_idx) < eff_total;
  assign sweep     = (state == S_CLR) || (state == S_FMT);

  // Shared limit unit: marks the bits of one map word whose block number lies
  // below a limit. Clear and format use it for the written pattern, allocate for the
  // bits that lie below the effective total.
  assign lim_op   = sweep ? fmt_rsv : eff_total;
  assign base_op  = sweep ? sw_base : chk_base;
  assign lim_diff = {1'b0, BASE_W'(lim_op)} - {1'b0, base_op};
  assign lim_neg  = lim_diff[BASE_W];
  assign lim_end  = lim_neg || (lim_diff[BASE_W-1:0] <= WB_BASE);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      lim_mask[b] = !lim_neg && (lim_diff[BASE_W-1:0] > BASE_W'(b));
    end
  end

  assign free_mask = ~ram_rdata & lim_mask;
  assign free_any  = |free_mask;

  always_comb begin
    free_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_mask[b]) begin
        free_pos = BIT_W'(b);
      end
    end
  end

  // Word number by reciprocal multiplication; exact for every 12-bit index.
  assign div_prod = PW'(req_idx) * PW'(DIV_M);
  assign div_quo  = WA_W'(div_prod >> DIV_SH);
  assign div_back = DW'(div_q) * DW'(WORD_BITS);

  assign bit_pos  = div_rem[BIT_W-1:0];
  assign bit_one  = WORD_BITS'(1) << bit_pos;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sw_addr;
    ram_wdata = lim_mask;
    ram_raddr = (state == S_SCAN) ? iss_addr : div_q;
    case (state)
      S_CLR, S_FMT: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        ram_we    = chk_valid && free_any;
        ram_waddr = chk_addr;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << free_pos);
      end
      S_EV: begin
        ram_waddr = div_q;
        if (req_op == bba_pkg::OP_WRITE) begin
          ram_we    = 1'b1;
          ram_wdata = req_val ? (ram_rdata | bit_one) : (ram_rdata & ~bit_one);
        end else if (req_op == bba_pkg::OP_FREE) begin
          ram_we    = ram_rdata[bit_pos];
          ram_wdata = ram_rdata & ~bit_one;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks    <= bba_pkg::TOTAL_RESET;
      reserved_blocks <= bba_pkg::RESERVE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        bba_pkg::REG_TOTAL:    total_blocks    <= cfg_wdata;
        bba_pkg::REG_RESERVED: reserved_blocks <= cfg_wdata[bba_pkg::IDX_W-1:0];
        default:               total_blocks    <= total_blocks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      sw_addr     <= '0;
      sw_base     <= '0;
      fmt_rsv     <= '0;
      free_blocks <= '0;
      chk_valid   <= 1'b0;
      iss_done    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // In S_PUT the output register is refilled below when it frees up.
      if (m_tvalid && m_tready && (state != S_PUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLR, S_FMT: begin
          if (sw_addr == LAST_WORD) begin
            state <= (state == S_CLR) ? S_IDLE : S_PUT;
          end else begin
            sw_addr <= sw_addr + 1'b1;
            sw_base <= sw_base + WB_BASE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            req_op  <= in_op;
            req_idx <= in_idx;
            req_val <= in_val;
            res_bit <= 1'b0;
            case (in_op)
              bba_pkg::OP_FORMAT: begin
                res_block   <= '0;
                res_status  <= bba_pkg::ST_OK;
                fmt_rsv     <= eff_rsv;
                free_blocks <= eff_total - eff_rsv;
                sw_addr     <= '0;
                sw_base     <= '0;
                state       <= S_FMT;
              end
              bba_pkg::OP_READ, bba_pkg::OP_WRITE, bba_pkg::OP_FREE: begin
                res_block <= in_idx;
                if (in_range) begin
                  res_status <= bba_pkg::ST_OK;
                  state      <= S_DIV;
                end else begin
                  res_status <= bba_pkg::ST_RANGE;
                  state      <= S_PUT;
                end
              end
              bba_pkg::OP_ALLOC: begin
                res_block <= '0;
                iss_addr  <= '0;
                iss_base  <= '0;
                iss_done  <= 1'b0;
                chk_valid <= 1'b0;
                if (free_blocks == '0) begin
                  res_status <= bba_pkg::ST_NOFREE;
                  state      <= S_PUT;
                end else begin
                  res_status <= bba_pkg::ST_OK;
                  state      <= S_SCAN;
                end
              end
              default: begin
                res_block  <= in_idx;
                res_status <= bba_pkg::ST_OK;
                state      <= S_PUT;
              end
            endcase
          end
        end
        S_DIV: begin
          div_q <= div_quo;
          state <= S_RA;
        end
        S_RA: begin
          // The bit offset follows from the registered word number.
          div_rem <= DW'(req_idx) - div_back;
          state   <= S_EV;
        end
        S_EV: begin
          if (req_op == bba_pkg::OP_READ) begin
            res_bit <= ram_rdata[bit_pos];
          end else if (req_op == bba_pkg::OP_FREE) begin
            if (!ram_rdata[bit_pos]) begin
              res_status <= bba_pkg::ST_ALREADY;
            end else if (free_blocks != bba_pkg::COUNT_MAX) begin
              free_blocks <= free_blocks + 1'b1;
            end
          end
          state <= S_PUT;
        end
        S_SCAN: begin
          // The read of the next word is issued while the previous word is checked.
          chk_valid <= !iss_done;
          chk_addr  <= iss_addr;
          chk_base  <= iss_base;
          if (!iss_done) begin
            if (iss_addr == LAST_WORD) begin
              iss_done <= 1'b1;
            end else begin
              iss_addr <= iss_addr + 1'b1;
              iss_base <= iss_base + WB_BASE;
            end
          end
          if (chk_valid) begin
            if (free_any) begin
              res_block   <= bba_pkg::IDX_W'(chk_base + BASE_W'(free_pos));
              free_blocks <= free_blocks - 1'b1;
              state       <= S_PUT;
            end else if (lim_end || (chk_addr == LAST_WORD)) begin
              res_status <= bba_pkg::ST_NOFREE;
              state      <= S_PUT;
            end
          end
        end
        S_PUT: begin
          if (!m_tvalid || m_tready) begin
            out_block  <= res_block;
            out_bit    <= res_bit;
            out_count  <= free_blocks;
            out_status <= res_status;
            m_tvalid   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {4'b0000, out_status, out_count, out_bit, out_block};

`ifndef SYNTHESIS
  // An accepted word keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an operation is still running");

  // The bit offset used on the map word lies inside one map word.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_EV) |-> (div_rem < DW'(WORD_BITS)))
    else $error("bit offset not below the word size");

  // During a scan the map is written only for a checked word with a free bit.
  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && ram_we) |-> (chk_valid && free_any))
    else $error("map written during scan without a free bit found");

  // An allocation that succeeds lowers the free count by one.
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && chk_valid && free_any) |=>
      (free_blocks == $past(free_blocks) - 1'b1))
    else $error("free count not decremented on allocation");
`endif

endmodule

`default_nettype wire
